// ===== hdl/c_style_token_scanner_defines.svh =====
// Assertion macros shared by the token scanner RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef C_STYLE_TOKEN_SCANNER_DEFINES_SVH
`define C_STYLE_TOKEN_SCANNER_DEFINES_SVH
`ifndef SYNTHESIS
`define CTS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cts: same-cycle check failed");
`define CTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cts: next-cycle check failed");
`else
`define CTS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define CTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/cts_pkg.sv =====
// Types, constants and character-class functions of the token scanner.
// No dependencies; imported by every module of the block.
`default_nettype none
package cts_pkg;
	localparam int CTS_POS_WIDTH = 32;
	localparam int QUEUE_DEPTH   = 4;
	localparam int TOK_DEPTH     = 4;
	localparam int KIND_W        = 6;
	localparam int OUT_W         = 32;
	localparam int WIDE_W        = 64;

	typedef logic [7:0]        char_t;
	typedef logic [KIND_W-1:0] kind_t;

	typedef enum logic [3:0] {
		M_IDLE, M_OP, M_LINE, M_BLOCK, M_ZERO, M_INT, M_REAL, M_HEX, M_STR, M_IDENT
	} mode_t;

	localparam kind_t K_PLUS_EQ  = 6'd0;
	localparam kind_t K_INCR     = 6'd1;
	localparam kind_t K_PLUS     = 6'd2;
	localparam kind_t K_MINUS_EQ = 6'd3;
	localparam kind_t K_DECR     = 6'd4;
	localparam kind_t K_MINUS    = 6'd5;
	localparam kind_t K_STAR_EQ  = 6'd6;
	localparam kind_t K_STAR     = 6'd7;
	localparam kind_t K_SLASH_EQ = 6'd8;
	localparam kind_t K_SLASH    = 6'd9;
	localparam kind_t K_LE       = 6'd10;
	localparam kind_t K_SHL      = 6'd11;
	localparam kind_t K_LT       = 6'd12;
	localparam kind_t K_GE       = 6'd13;
	localparam kind_t K_SHR      = 6'd14;
	localparam kind_t K_GT       = 6'd15;
	localparam kind_t K_EQEQ     = 6'd16;
	localparam kind_t K_ASSIGN   = 6'd17;
	localparam kind_t K_NE       = 6'd18;
	localparam kind_t K_NOT      = 6'd19;
	localparam kind_t K_LPAREN   = 6'd20;
	localparam kind_t K_RPAREN   = 6'd21;
	localparam kind_t K_LBRACK   = 6'd22;
	localparam kind_t K_RBRACK   = 6'd23;
	localparam kind_t K_LBRACE   = 6'd24;
	localparam kind_t K_RBRACE   = 6'd25;
	localparam kind_t K_DEFINE   = 6'd26;
	localparam kind_t K_COLON    = 6'd27;
	localparam kind_t K_SEMI     = 6'd28;
	localparam kind_t K_LAND     = 6'd29;
	localparam kind_t K_AND      = 6'd30;
	localparam kind_t K_LOR      = 6'd31;
	localparam kind_t K_OR       = 6'd32;
	localparam kind_t K_HEX      = 6'd33;
	localparam kind_t K_INT      = 6'd34;
	localparam kind_t K_REAL     = 6'd35;
	localparam kind_t K_STR1     = 6'd36;
	localparam kind_t K_STR2     = 6'd37;
	localparam kind_t K_UNT_EOL  = 6'd38;
	localparam kind_t K_UNT_EOT  = 6'd39;
	localparam kind_t K_IDENT    = 6'd40;
	localparam kind_t K_UNDEF    = 6'd41;
	localparam kind_t K_END      = 6'd42;
	localparam kind_t K_NONE     = 6'd63;

	localparam char_t CH_NUL    = 8'h00;
	localparam char_t CH_TAB    = 8'h09;
	localparam char_t CH_LF     = 8'h0A;
	localparam char_t CH_CR     = 8'h0D;
	localparam char_t CH_SPACE  = 8'h20;
	localparam char_t CH_BANG   = 8'h21;
	localparam char_t CH_DQUOTE = 8'h22;
	localparam char_t CH_AMP    = 8'h26;
	localparam char_t CH_SQUOTE = 8'h27;
	localparam char_t CH_LPAREN = 8'h28;
	localparam char_t CH_RPAREN = 8'h29;
	localparam char_t CH_STAR   = 8'h2A;
	localparam char_t CH_PLUS   = 8'h2B;
	localparam char_t CH_MINUS  = 8'h2D;
	localparam char_t CH_DOT    = 8'h2E;
	localparam char_t CH_SLASH  = 8'h2F;
	localparam char_t CH_ZERO   = 8'h30;
	localparam char_t CH_NINE   = 8'h39;
	localparam char_t CH_COLON  = 8'h3A;
	localparam char_t CH_SEMI   = 8'h3B;
	localparam char_t CH_LT     = 8'h3C;
	localparam char_t CH_EQ     = 8'h3D;
	localparam char_t CH_GT     = 8'h3E;
	localparam char_t CH_UP_A   = 8'h41;
	localparam char_t CH_UP_F   = 8'h46;
	localparam char_t CH_UP_X   = 8'h58;
	localparam char_t CH_UP_Z   = 8'h5A;
	localparam char_t CH_LBRACK = 8'h5B;
	localparam char_t CH_RBRACK = 8'h5D;
	localparam char_t CH_UNDER  = 8'h5F;
	localparam char_t CH_LO_A   = 8'h61;
	localparam char_t CH_LO_F   = 8'h66;
	localparam char_t CH_LO_X   = 8'h78;
	localparam char_t CH_LO_Z   = 8'h7A;
	localparam char_t CH_LBRACE = 8'h7B;
	localparam char_t CH_PIPE   = 8'h7C;
	localparam char_t CH_RBRACE = 8'h7D;

	// classified source word handed from front to back
	typedef struct packed {
		char_t sym;
		logic  eot;
		logic  digit;
		logic  hexd;
		logic  word;
		logic  id_start;
		logic  space;
		logic  quote;
		logic  single;
		logic  now;
		kind_t now_kind;
	} cls_t;

	function automatic logic is_digit(input char_t c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_alpha(input char_t c);
		return ((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
	endfunction

	function automatic logic is_hexd(input char_t c);
		return is_digit(c) || ((c >= CH_LO_A) && (c <= CH_LO_F)) ||
			((c >= CH_UP_A) && (c <= CH_UP_F));
	endfunction

	function automatic logic is_space(input char_t c);
		return (c == CH_SPACE) || (c == CH_CR) || (c == CH_LF) || (c == CH_TAB);
	endfunction

	function automatic kind_t op_single(input char_t f);
		kind_t k;
		case (f)
			CH_PLUS:  k = K_PLUS;
			CH_MINUS: k = K_MINUS;
			CH_STAR:  k = K_STAR;
			CH_SLASH: k = K_SLASH;
			CH_LT:    k = K_LT;
			CH_GT:    k = K_GT;
			CH_EQ:    k = K_ASSIGN;
			CH_BANG:  k = K_NOT;
			CH_COLON: k = K_COLON;
			CH_AMP:   k = K_AND;
			CH_PIPE:  k = K_OR;
			default:  k = K_NONE;
		endcase
		return k;
	endfunction

	function automatic kind_t op_pair(input char_t f, input char_t c);
		kind_t k;
		k = K_NONE;
		case (f)
			CH_PLUS: begin
				if (c == CH_EQ) k = K_PLUS_EQ;
				else if (c == CH_PLUS) k = K_INCR;
			end
			CH_MINUS: begin
				if (c == CH_EQ) k = K_MINUS_EQ;
				else if (c == CH_MINUS) k = K_DECR;
			end
			CH_STAR:  if (c == CH_EQ) k = K_STAR_EQ;
			CH_SLASH: if (c == CH_EQ) k = K_SLASH_EQ;
			CH_LT: begin
				if (c == CH_EQ) k = K_LE;
				else if (c == CH_LT) k = K_SHL;
			end
			CH_GT: begin
				if (c == CH_EQ) k = K_GE;
				else if (c == CH_GT) k = K_SHR;
			end
			CH_EQ:    if (c == CH_EQ) k = K_EQEQ;
			CH_BANG:  if (c == CH_EQ) k = K_NE;
			CH_COLON: if (c == CH_EQ) k = K_DEFINE;
			CH_AMP:   if (c == CH_AMP) k = K_LAND;
			CH_PIPE:  if (c == CH_PIPE) k = K_LOR;
			default:  k = K_NONE;
		endcase
		return k;
	endfunction

	function automatic kind_t op_now(input char_t c);
		kind_t k;
		case (c)
			CH_LPAREN: k = K_LPAREN;
			CH_RPAREN: k = K_RPAREN;
			CH_LBRACK: k = K_LBRACK;
			CH_RBRACK: k = K_RBRACK;
			CH_LBRACE: k = K_LBRACE;
			CH_RBRACE: k = K_RBRACE;
			CH_SEMI:   k = K_SEMI;
			default:   k = K_NONE;
		endcase
		return k;
	endfunction
endpackage
`default_nettype wire

// ===== hdl/cts_front.sv =====
// Front end: accepts source bytes, classifies them and tags each with its position.
// Depends on cts_pkg.
`default_nettype none
module cts_front import cts_pkg::*; #(
	parameter int POS_WIDTH = CTS_POS_WIDTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire logic                 full,
	input  wire char_t                symbol,
	input  wire logic                 end_of_text,
	output logic                      wr,
	output cls_t                      wr_cls,
	output logic [POS_WIDTH-1:0]      wr_pos
);
	localparam logic [POS_WIDTH-1:0] POS_ONE = 1;

	logic [POS_WIDTH-1:0] pos_q;
	kind_t now_k;

	assign wr     = push && !full;
	assign wr_pos = pos_q;
	assign now_k  = op_now(symbol);

	always_comb begin
		wr_cls.sym      = symbol;
		wr_cls.eot      = end_of_text || (symbol == CH_NUL);
		wr_cls.digit    = is_digit(symbol);
		wr_cls.hexd     = is_hexd(symbol);
		wr_cls.word     = is_alpha(symbol) || is_digit(symbol) || (symbol == CH_UNDER);
		wr_cls.id_start = is_alpha(symbol) || (symbol == CH_UNDER);
		wr_cls.space    = is_space(symbol);
		wr_cls.quote    = (symbol == CH_DQUOTE) || (symbol == CH_SQUOTE);
		wr_cls.single   = op_single(symbol) != K_NONE;
		wr_cls.now      = now_k != K_NONE;
		wr_cls.now_kind = now_k;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (wr) begin
			pos_q <= wr_cls.eot ? '0 : pos_q + POS_ONE;
		end
	end
endmodule
`default_nettype wire

// ===== hdl/cts_queue.sv =====
// Short word queue between the classifying front end and the scanning back end.
// Depends on cts_pkg for its depth.
`default_nettype none
module cts_queue import cts_pkg::*; #(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         wr,
	input  wire logic [W-1:0] wr_data,
	input  wire logic         rd,
	output logic [W-1:0]      rd_data,
	output logic              full,
	output logic              empty
);
	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);

	logic [W-1:0]  mem_q [QUEUE_DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr, do_rd;

	assign full    = cnt_q == CW'(QUEUE_DEPTH);
	assign empty   = cnt_q == '0;
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wp_q <= (wp_q == LAST) ? '0 : wp_q + 1'b1;
			if (do_rd) rp_q <= (rp_q == LAST) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + CW'(do_wr) - CW'(do_rd);
		end
	end
endmodule
`default_nettype wire

// ===== hdl/cts_back.sv =====
// Back end: token state machine over classified words, plus the token output queue.
// Depends on cts_pkg and c_style_token_scanner_defines.svh.
`default_nettype none
`include "c_style_token_scanner_defines.svh"
module cts_back import cts_pkg::*; #(
	parameter int POS_WIDTH = CTS_POS_WIDTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire cls_t                 in_cls,
	input  wire logic [POS_WIDTH-1:0] in_pos,
	output logic                      take,
	output logic                      empty,
	input  wire logic                 pop,
	output kind_t                     token_kind,
	output logic [OUT_W-1:0]          token_start,
	output logic [OUT_W-1:0]          token_length,
	output logic                      last_of_run
);
	localparam int TAW = $clog2(TOK_DEPTH);
	localparam int TCW = $clog2(TOK_DEPTH + 1);
	localparam logic [TAW-1:0] TLAST = TAW'(TOK_DEPTH - 1);
	localparam logic [POS_WIDTH-1:0] LEN_ONE = 1;
	localparam logic [POS_WIDTH-1:0] LEN_TWO = 2;

	mode_t                mode_q, mode_n;
	char_t                pend_q, pend_n;
	logic [POS_WIDTH-1:0] lex_q, lex_n;
	logic                 dq_q, dq_n, star_q, star_n;
	logic                 used;

	logic [POS_WIDTH-1:0] run_len, pos_p1;
	kind_t                pair_k, pend_k, fall_k;
	char_t                sym, close_q;
	logic                 is_comment;

	logic                 a_v, b_v;
	kind_t                a_kind, b_kind;
	logic [POS_WIDTH-1:0] a_start, a_len, b_start, b_len;

	kind_t                tk_kind  [TOK_DEPTH];
	logic                 tk_last  [TOK_DEPTH];
	logic [POS_WIDTH-1:0] tk_start [TOK_DEPTH];
	logic [POS_WIDTH-1:0] tk_len   [TOK_DEPTH];
	logic [TAW-1:0]       wp_q, rp_q, wp1, wp2, b_addr;
	logic [TCW-1:0]       tcnt_q;
	logic [1:0]           nw;
	logic                 pop_ok;
	logic [WIDE_W-1:0]    start_wide, len_wide;

	assign sym        = in_cls.sym;
	assign run_len    = in_pos - lex_q;
	assign pos_p1     = in_pos + LEN_ONE;
	assign pair_k     = op_pair(pend_q, sym);
	assign pend_k     = op_single(pend_q);
	assign fall_k     = (pend_k == K_NONE) ? K_UNDEF : pend_k;
	assign close_q    = dq_q ? CH_DQUOTE : CH_SQUOTE;
	assign is_comment = (pend_q == CH_SLASH) && ((sym == CH_SLASH) || (sym == CH_STAR));

	// room for two tokens before a word is taken
	assign take = in_valid && (tcnt_q <= TCW'(TOK_DEPTH - 2));

	// next state
	always_comb begin
		mode_n = mode_q;
		pend_n = pend_q;
		lex_n  = lex_q;
		dq_n   = dq_q;
		star_n = star_q;
		used   = 1'b0;
		if (in_cls.eot) begin
			mode_n = M_IDLE;
			pend_n = '0;
			lex_n  = '0;
			dq_n   = 1'b0;
			star_n = 1'b0;
		end else begin
			case (mode_q)
				M_OP: begin
					used = 1'b1;
					if (pend_q == CH_SLASH && sym == CH_SLASH) begin
						mode_n = M_LINE;
					end else if (pend_q == CH_SLASH && sym == CH_STAR) begin
						mode_n = M_BLOCK;
						star_n = 1'b0;
					end else begin
						used   = pair_k != K_NONE;
						mode_n = M_IDLE;
					end
				end
				M_LINE: begin
					used = 1'b1;
					if (sym == CH_LF) mode_n = M_IDLE;
				end
				M_BLOCK: begin
					used = 1'b1;
					if (star_q && sym == CH_SLASH) begin
						mode_n = M_IDLE;
						star_n = 1'b0;
					end else begin
						star_n = sym == CH_STAR;
					end
				end
				M_ZERO, M_INT: begin
					if (mode_q == M_ZERO && (sym == CH_LO_X || sym == CH_UP_X)) begin
						mode_n = M_HEX;
						used   = 1'b1;
					end else if (in_cls.digit) begin
						mode_n = M_INT;
						used   = 1'b1;
					end else if (sym == CH_DOT) begin
						mode_n = M_REAL;
						used   = 1'b1;
					end else begin
						mode_n = M_IDLE;
					end
				end
				M_REAL: begin
					used = in_cls.digit;
					if (!in_cls.digit) mode_n = M_IDLE;
				end
				M_HEX: begin
					used = in_cls.hexd;
					if (!in_cls.hexd) mode_n = M_IDLE;
				end
				M_IDENT: begin
					used = in_cls.word;
					if (!in_cls.word) mode_n = M_IDLE;
				end
				M_STR: begin
					used = 1'b1;
					if (sym == close_q || sym == CH_LF) mode_n = M_IDLE;
				end
				default: begin
					mode_n = M_IDLE;
				end
			endcase
			if (!used) begin
				if (in_cls.space || in_cls.now) begin
					mode_n = M_IDLE;
				end else if (in_cls.single) begin
					mode_n = M_OP;
					pend_n = sym;
					lex_n  = in_pos;
				end else if (in_cls.digit) begin
					mode_n = (sym == CH_ZERO) ? M_ZERO : M_INT;
					lex_n  = in_pos;
				end else if (in_cls.quote) begin
					mode_n = M_STR;
					dq_n   = sym == CH_DQUOTE;
					lex_n  = pos_p1;
				end else if (in_cls.id_start) begin
					mode_n = M_IDENT;
					lex_n  = in_pos;
				end
			end
		end
	end

	// token outputs: a ends the pending lexeme, b comes from the byte itself
	always_comb begin
		a_v     = 1'b0;
		a_kind  = K_NONE;
		a_start = lex_q;
		a_len   = run_len;
		b_v     = 1'b0;
		b_kind  = K_NONE;
		b_start = in_pos;
		b_len   = LEN_ONE;
		if (in_cls.eot) begin
			case (mode_q)
				M_OP: begin
					a_v    = 1'b1;
					a_kind = fall_k;
					a_len  = LEN_ONE;
				end
				M_ZERO, M_INT: begin
					a_v    = 1'b1;
					a_kind = K_INT;
				end
				M_REAL: begin
					a_v    = 1'b1;
					a_kind = K_REAL;
				end
				M_HEX: begin
					a_v    = 1'b1;
					a_kind = K_HEX;
				end
				M_IDENT: begin
					a_v    = 1'b1;
					a_kind = K_IDENT;
				end
				M_STR: begin
					a_v    = 1'b1;
					a_kind = K_UNT_EOT;
				end
				default: begin
					a_v = 1'b0;
				end
			endcase
			b_v    = 1'b1;
			b_kind = K_END;
			b_len  = '0;
		end else begin
			case (mode_q)
				M_OP: begin
					a_v = !is_comment;
					if (pair_k != K_NONE) begin
						a_kind = pair_k;
						a_len  = LEN_TWO;
					end else begin
						a_kind = fall_k;
						a_len  = LEN_ONE;
					end
				end
				M_ZERO, M_INT: begin
					a_v    = !used;
					a_kind = K_INT;
				end
				M_REAL: begin
					a_v    = !used;
					a_kind = K_REAL;
				end
				M_HEX: begin
					a_v    = !used;
					a_kind = K_HEX;
				end
				M_IDENT: begin
					a_v    = !used;
					a_kind = K_IDENT;
				end
				M_STR: begin
					if (sym == close_q) begin
						a_v    = 1'b1;
						a_kind = dq_q ? K_STR2 : K_STR1;
					end else if (sym == CH_LF) begin
						a_v    = 1'b1;
						a_kind = K_UNT_EOL;
					end
				end
				default: begin
					a_v = 1'b0;
				end
			endcase
			if (!used && !in_cls.space) begin
				if (in_cls.now) begin
					b_v    = 1'b1;
					b_kind = in_cls.now_kind;
				end else if (!(in_cls.single || in_cls.digit || in_cls.quote ||
						in_cls.id_start)) begin
					b_v    = 1'b1;
					b_kind = K_UNDEF;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			pend_q <= '0;
			lex_q  <= '0;
			dq_q   <= 1'b0;
			star_q <= 1'b0;
		end else if (take) begin
			mode_q <= mode_n;
			pend_q <= pend_n;
			lex_q  <= lex_n;
			dq_q   <= dq_n;
			star_q <= star_n;
		end
	end

	// token queue, up to two writes per cycle
	assign wp1    = (wp_q == TLAST) ? '0 : wp_q + 1'b1;
	assign wp2    = (wp1 == TLAST) ? '0 : wp1 + 1'b1;
	assign b_addr = a_v ? wp1 : wp_q;
	assign nw     = take ? (2'(a_v) + 2'(b_v)) : 2'd0;
	assign empty  = tcnt_q == '0;
	assign pop_ok = pop && !empty;

	always_ff @(posedge clk) begin
		if (take && a_v) begin
			tk_kind[wp_q]  <= a_kind;
			tk_last[wp_q]  <= !b_v;
			tk_start[wp_q] <= a_start;
			tk_len[wp_q]   <= a_len;
		end
		if (take && b_v) begin
			tk_kind[b_addr]  <= b_kind;
			tk_last[b_addr]  <= 1'b1;
			tk_start[b_addr] <= b_start;
			tk_len[b_addr]   <= b_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			tcnt_q <= '0;
		end else begin
			case (nw)
				2'd1:    wp_q <= wp1;
				2'd2:    wp_q <= wp2;
				default: wp_q <= wp_q;
			endcase
			if (pop_ok) rp_q <= (rp_q == TLAST) ? '0 : rp_q + 1'b1;
			tcnt_q <= tcnt_q + TCW'(nw) - TCW'(pop_ok);
		end
	end

	assign start_wide   = WIDE_W'(tk_start[rp_q]);
	assign len_wide     = WIDE_W'(tk_len[rp_q]);
	assign token_kind   = tk_kind[rp_q];
	assign token_start  = start_wide[OUT_W-1:0];
	assign token_length = len_wide[OUT_W-1:0];
	assign last_of_run  = tk_last[rp_q];

	`CTS_ASSERT_IMPL(a_tok_bound, clk, arst_n, 1'b1, tcnt_q <= TCW'(TOK_DEPTH))
	`CTS_ASSERT_IMPL(a_eot_end, clk, arst_n, take && in_cls.eot, b_v && b_kind == K_END)
	`CTS_ASSERT_NEXT(a_eot_clear, clk, arst_n, take && in_cls.eot, mode_q == M_IDLE && lex_q == '0)
	`CTS_ASSERT_IMPL(a_str_eol, clk, arst_n, take && !in_cls.eot && mode_q == M_STR && sym == CH_LF && dq_q == 1'b1, a_v && a_kind == K_UNT_EOL)
endmodule
`default_nettype wire

// ===== hdl/c_style_token_scanner.sv =====
// Top level of the C-style token scanner: front end, word queue, back end.
// Depends on cts_pkg, cts_front, cts_queue and cts_back.
`default_nettype none
// Bytes enter through push/full, one per cycle while full is low; tokens leave
// through empty/pop as kind, start, length and a last-of-run flag. The back end
// scans one queued byte per cycle whenever its four-entry token queue has room
// for two tokens, so sustained input is one byte per cycle while tokens are
// popped in time; a byte that ends one token and forms another yields two tokens,
// which leave through two pops. A token is visible in the cycle after the byte
// that completes it is taken. End of text (end_of_text high or a zero byte)
// flushes any open token, adds an end token and restarts the position count at zero.
module c_style_token_scanner import cts_pkg::*; #(
	parameter int POS_WIDTH = CTS_POS_WIDTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	output logic              full,
	input  wire logic [7:0]   symbol,
	input  wire logic         end_of_text,
	output logic              empty,
	input  wire logic         pop,
	output logic [5:0]        token_kind,
	output logic [OUT_W-1:0]  token_start,
	output logic [OUT_W-1:0]  token_length,
	output logic              last_of_run
);
	localparam int QW = $bits(cls_t) + POS_WIDTH;

	logic                 f_wr;
	cls_t                 f_cls;
	logic [POS_WIDTH-1:0] f_pos;
	logic [QW-1:0]        q_rd_data;
	logic                 q_empty, b_take;
	cls_t                 q_cls;
	logic [POS_WIDTH-1:0] q_pos;

	cts_front #(.POS_WIDTH(POS_WIDTH)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.symbol      (symbol),
		.end_of_text (end_of_text),
		.wr          (f_wr),
		.wr_cls      (f_cls),
		.wr_pos      (f_pos)
	);

	cts_queue #(.W(QW)) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (f_wr),
		.wr_data ({f_cls, f_pos}),
		.rd      (b_take),
		.rd_data (q_rd_data),
		.full    (full),
		.empty   (q_empty)
	);

	assign {q_cls, q_pos} = q_rd_data;

	cts_back #(.POS_WIDTH(POS_WIDTH)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (!q_empty),
		.in_cls       (q_cls),
		.in_pos       (q_pos),
		.take         (b_take),
		.empty        (empty),
		.pop          (pop),
		.token_kind   (token_kind),
		.token_start  (token_start),
		.token_length (token_length),
		.last_of_run  (last_of_run)
	);
endmodule
`default_nettype wire
